// ----- sv/bspe_pkg.sv -----
// ----------------------------------------------------------------------------
// B-spline point evaluator package
// Shared constants, codes and types for the evaluator modules.
// ----------------------------------------------------------------------------
package bspe_pkg;

  localparam int MaxPoints = 32;
  localparam int MaxDegree = 7;
  localparam int KnotDepth = 64;
  localparam int PtAw = $clog2(MaxPoints);
  localparam int KnAw = $clog2(KnotDepth);

  typedef enum logic [1:0] {
    REQ_POINT = 2'd0,
    REQ_KNOT  = 2'd1,
    REQ_EVAL  = 2'd2,
    REQ_BAD   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD     = 2'd1,
    ST_NO_SPAN = 2'd2,
    ST_ZERO    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_DEGREE = 2'd0,
    CFG_NUM    = 2'd1,
    CFG_MODE   = 2'd2
  } cfg_e;

  // Divider handshake between sequencer and the shared divide unit.
  typedef struct packed {
    logic        start;
    logic [47:0] num;   // nonnegative numerator
    logic [10:0] den;   // positive divisor
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] quo;
  } div_rsp_t;

endpackage

// ----- sv/bspe_div.sv -----
// ----------------------------------------------------------------------------
// Shared radix-2 divider
// Unsigned restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bspe_div import bspe_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [47:0] quo_q, quo_d;
  logic [10:0] rem_q, rem_d;
  logic [10:0] den_q, den_d;
  logic [11:0] trial;

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    trial  = {rem_q, quo_q[47]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 6'd0;
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = 11'(trial - {1'b0, den_q});
        quo_d = {quo_q[46:0], 1'b1};
      end else begin
        rem_d = trial[10:0];
        quo_d = {quo_q[46:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd47) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

// ----- sv/b_spline_point_evaluator.sv -----
// ----------------------------------------------------------------------------
// B-spline point evaluator
// Loads control points and knots, and evaluates one curve point per request
// with de Boor's algorithm on a shared divider and blend unit.
// ----------------------------------------------------------------------------
// Usage: one input channel (in_valid_i / in_stall_o) carries load and evaluate
// requests; one output channel (out_valid_o / out_stall_i) returns exactly one
// result transaction per request. Configuration is written through cfg_we_i,
// cfg_idx_i and cfg_data_i while the block is idle. The user must keep to
// this; the block itself does not enforce it. A load or rejected request
// has its result loaded into the output register in the check state. An
// evaluation runs setup, tests spans in turn, fetches each control point,
// runs p(p+1)/2 alpha steps and wraps up. A step that divides fetches two
// knots, runs a bit-serial division, does six blend multiplies on one
// shared multiplier and advances; when the divisor is zero or alpha is
// clamped to zero, the division is skipped.
// The block takes one request at a time and stalls its input until the result
// has left; the input opens the cycle after the result is taken.
// A finished result waits in the output register while out_stall_i is high.
// Reset clears control state and restores degree 3, four points and computed
// knots; the point and knot memories hold no reset value and need no sweep.
// ----------------------------------------------------------------------------
module b_spline_point_evaluator import bspe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [5:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [5:0]         index_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  input  logic [9:0]         knot_value_i,
  input  logic [16:0]        progress_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic [5:0]         span_found_o,
  output logic [1:0]         status_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_LOX, S_HIX, S_MKX, S_SRCH_A, S_SRCH_B, S_SRCH_C,
    S_LOAD_A, S_LOAD_B, S_AL_A, S_AL_B, S_AL_C, S_AL_D, S_DIV, S_BL_RD, S_BL_M1,
    S_BL_M2, S_BL_WR, S_NEXT, S_DONE, S_OUT
  } state_e;

  state_e state_q, state_d;

  logic [2:0] degree_q;
  logic [5:0] num_q;
  logic       mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      degree_q <= 3'd3;
      num_q    <= 6'd4;
      mode_q   <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DEGREE: degree_q <= cfg_data_i[2:0];
        CFG_NUM:    num_q    <= cfg_data_i;
        CFG_MODE:   mode_q   <= cfg_data_i[0];
        default:    ;
      endcase
    end
  end

  logic [1:0]  req_q;
  logic [5:0]  index_q;
  logic [31:0] cx_q, cy_q, cz_q;
  logic [9:0]  kv_q;
  logic [16:0] prog_q;

  // Memories.
  logic [95:0] pt_mem [MaxPoints];
  logic [9:0]  kn_mem [KnotDepth];
  logic [95:0] pt_rd_q;
  logic [9:0]  kn_rd_q;
  logic [PtAw-1:0] pt_ra;
  logic [KnAw-1:0] kn_ra;
  logic        pt_we, kn_we;

  always_ff @(posedge clk_i) begin
    if (pt_we) pt_mem[index_q[PtAw-1:0]] <= {cx_q, cy_q, cz_q};
    pt_rd_q <= pt_mem[pt_ra];
  end

  always_ff @(posedge clk_i) begin
    if (kn_we) kn_mem[index_q[KnAw-1:0]] <= kv_q;
    kn_rd_q <= kn_mem[kn_ra];
  end

  // Triangle working registers (de Boor column).
  logic signed [31:0] dx_q [MaxDegree+1];
  logic signed [31:0] dy_q [MaxDegree+1];
  logic signed [31:0] dz_q [MaxDegree+1];

  logic [6:0]  ki_q, ki_d;       // knot index argument
  logic [10:0] ka_q, ka_d;       // latched knot (lo, t_j in search, or ta)
  logic signed [28:0] xv_q, xv_d;   // x in Q.16
  logic [5:0]  k_q, k_d;
  logic [5:0]  j_q, j_d;
  logic [2:0]  r_q, r_d;
  logic [16:0] a_q, a_d;
  logic [1:0]  st_q, st_d;
  logic [1:0]  c_q, c_d;
  logic signed [49:0] acc_q, acc_d;
  logic        blend_wr, dload;
  logic [2:0]  dj;

  logic signed [31:0] ox_q, oy_q, oz_q;
  logic [5:0]  osp_q;
  logic [1:0]  ost_q;
  logic        ov_q;
  logic        out_load;
  logic [31:0] rx_d, ry_d, rz_d;
  logic [5:0]  rsp_d;
  logic [1:0]  rst_d;

  // Computed knot value for index ki_q.
  logic [10:0] kcalc, kcalc_q;
  always_comb begin
    if (degree_q == 3'd1)
      kcalc = {4'd0, ki_q};
    else if (ki_q < {4'd0, degree_q})
      kcalc = '0;
    else if (ki_q < {1'b0, num_q})
      kcalc = {4'd0, ki_q - {4'd0, degree_q}};
    else
      kcalc = {5'd0, num_q - {3'd0, degree_q}};
  end
  // Both knot sources are registered from the index, so they arrive in the cycle after it is set.
  logic [10:0] kval;
  assign kval  = mode_q ? kcalc_q : {1'b0, kn_rd_q};
  assign kn_ra = ki_q[KnAw-1:0];

  div_req_t dreq;
  div_rsp_t drsp;
  bspe_div u_div (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(dreq), .rsp_o(drsp));

  // Shared multiplier: 18 x 32 signed.
  logic signed [17:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [49:0] prod;
  assign prod = mul_a * mul_b;

  logic [6:0]  len;
  logic        cfg_bad;
  logic signed [28:0] num_s;
  logic signed [28:0] kq;
  assign len     = {1'b0, num_q} + {4'd0, degree_q} + 7'd1;
  assign cfg_bad = (degree_q == 3'd0) || ({1'b0, num_q} < {4'd0, degree_q} + 7'd1) ||
                   (num_q > 6'(MaxPoints)) || (len > 7'(KnotDepth));
  assign kq      = {2'b0, kval, 16'd0};
  assign num_s   = xv_q - {2'b0, ka_q, 16'd0};

  logic signed [31:0] dlo, dhi;
  always_comb begin
    unique case (c_q)
      2'd0:    begin dlo = dx_q[j_q[2:0]-3'd1]; dhi = dx_q[j_q[2:0]]; end
      2'd1:    begin dlo = dy_q[j_q[2:0]-3'd1]; dhi = dy_q[j_q[2:0]]; end
      default: begin dlo = dz_q[j_q[2:0]-3'd1]; dhi = dz_q[j_q[2:0]]; end
    endcase
  end

  always_comb begin
    state_d = state_q;
    ki_d = ki_q; ka_d = ka_q; xv_d = xv_q;
    k_d = k_q; j_d = j_q; r_d = r_q; a_d = a_q; st_d = st_q; c_d = c_q;
    acc_d = acc_q;
    blend_wr = 1'b0; dload = 1'b0;
    pt_we = 1'b0; kn_we = 1'b0; out_load = 1'b0;
    pt_ra = '0; dj = '0;
    dreq  = '0;
    mul_a = '0; mul_b = '0;
    rx_d = '0; ry_d = '0; rz_d = '0; rsp_d = '0; rst_d = ST_OK;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_CHECK;
      S_CHECK: begin
        unique case (req_q)
          REQ_POINT: begin
            out_load = 1'b1; state_d = S_OUT;
            if ({1'b0, index_q} >= 7'(MaxPoints)) rst_d = ST_BAD;
            else pt_we = 1'b1;
          end
          REQ_KNOT: begin
            out_load = 1'b1; state_d = S_OUT;
            if ({1'b0, index_q} >= 7'(KnotDepth)) rst_d = ST_BAD;
            else kn_we = 1'b1;
          end
          REQ_EVAL: begin
            if (cfg_bad) begin
              rst_d = ST_BAD; out_load = 1'b1; state_d = S_OUT;
            end else begin
              ki_d = {4'd0, degree_q}; st_d = ST_OK; state_d = S_LOX;
            end
          end
          default: begin
            rst_d = ST_BAD; out_load = 1'b1; state_d = S_OUT;
          end
        endcase
      end
      S_LOX: begin
        // The knot at index p is fetched this cycle and shows up next cycle.
        ki_d = {1'b0, num_q}; state_d = S_HIX;
      end
      S_HIX: begin
        ka_d = kval; state_d = S_MKX;
      end
      S_MKX: begin
        mul_a = {1'b0, (prog_q > 17'd65536) ? 17'd65536 : prog_q};
        mul_b = 32'(signed'({1'b0, kval}) - signed'({1'b0, ka_q}));
        xv_d  = 29'(prod) + {2'b0, ka_q, 16'd0};
        ki_d  = {4'd0, degree_q}; j_d = {3'd0, degree_q};
        state_d = S_SRCH_A;
      end
      S_SRCH_A: begin
        ki_d = ki_q + 7'd1; state_d = S_SRCH_B;
      end
      S_SRCH_B: begin
        ka_d = kval; state_d = S_SRCH_C;
      end
      S_SRCH_C: begin
        if ({2'b0, ka_q, 16'd0} <= xv_q && xv_q <= kq) begin
          k_d = j_q; j_d = '0; state_d = S_LOAD_A;
        end else if (j_q + 6'd2 > num_q) begin
          rst_d = ST_NO_SPAN; out_load = 1'b1; state_d = S_OUT;
        end else begin
          j_d = j_q + 6'd1; ki_d = {1'b0, j_q + 6'd1}; state_d = S_SRCH_A;
        end
      end
      S_LOAD_A: begin
        pt_ra = PtAw'(j_q + k_q - {3'd0, degree_q});
        state_d = S_LOAD_B;
      end
      S_LOAD_B: begin
        pt_ra = PtAw'(j_q + k_q - {3'd0, degree_q});
        dload = 1'b1; dj = j_q[2:0];
        if (j_q[2:0] == degree_q) begin
          r_d = 3'd1; j_d = {3'd0, degree_q}; state_d = S_AL_A;
        end else begin
          j_d = j_q + 6'd1; state_d = S_LOAD_A;
        end
      end
      S_AL_A: begin
        ki_d = {1'b0, j_q + k_q - {3'd0, degree_q}}; state_d = S_AL_B;
      end
      S_AL_B: begin
        ki_d = {1'b0, j_q + 6'd1 + k_q - {3'd0, r_q}};
        state_d = S_AL_C;
      end
      S_AL_C: begin
        ka_d = kval; state_d = S_AL_D;
      end
      S_AL_D: begin
        if (kval == ka_q) begin
          a_d = '0; st_d = ST_ZERO; c_d = '0; state_d = S_BL_M1;
        end else if (kval < ka_q || num_s < 0) begin
          // Negative divisor or numerator: clamp handles the sign cases.
          if (kval < ka_q && num_s <= 0) begin
            // Quotient of two non-positive values is nonnegative.
            dreq.start = 1'b1;
            dreq.num   = 48'(-num_s);
            dreq.den   = ka_q - kval;
            state_d    = S_DIV;
          end else begin
            a_d = '0; c_d = '0; state_d = S_BL_M1;
          end
        end else begin
          dreq.start = 1'b1;
          dreq.num   = 48'(num_s);
          dreq.den   = kval - ka_q;
          state_d    = S_DIV;
        end
      end
      S_DIV: if (drsp.done) begin
        a_d = (drsp.quo > 48'd65536) ? 17'd65536 : drsp.quo[16:0];
        c_d = '0; state_d = S_BL_M1;
      end
      S_BL_M1: begin
        mul_a = signed'({1'b0, 17'd65536 - a_q});
        mul_b = dlo;
        acc_d = prod; state_d = S_BL_M2;
      end
      S_BL_M2: begin
        mul_a = signed'({1'b0, a_q});
        mul_b = dhi;
        acc_d = acc_q + prod; state_d = S_BL_WR;
      end
      S_BL_WR: begin
        blend_wr = 1'b1;
        if (c_q == 2'd2) state_d = S_NEXT;
        else begin c_d = c_q + 2'd1; state_d = S_BL_M1; end
      end
      S_NEXT: begin
        if (j_q[2:0] > r_q) begin
          j_d = j_q - 6'd1; state_d = S_AL_A;
        end else if (r_q < degree_q) begin
          r_d = r_q + 3'd1; j_d = {3'd0, degree_q}; state_d = S_AL_A;
        end else state_d = S_DONE;
      end
      S_DONE: begin
        rx_d = dx_q[degree_q]; ry_d = dy_q[degree_q]; rz_d = dz_q[degree_q];
        rsp_d = k_q; rst_d = st_q; out_load = 1'b1; state_d = S_OUT;
      end
      S_OUT: if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Truncating divide by 65536 toward zero.
  logic signed [49:0] blended;
  assign blended = (acc_q < 0) ? -((-acc_q) >>> 16) : (acc_q >>> 16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      req_q <= req_type_i; index_q <= index_i; cx_q <= coord_x_i;
      cy_q <= coord_y_i; cz_q <= coord_z_i; kv_q <= knot_value_i;
      prog_q <= progress_i;
    end
    kcalc_q <= kcalc;
    ki_q <= ki_d; ka_q <= ka_d; xv_q <= xv_d; k_q <= k_d;
    j_q <= j_d; r_q <= r_d; a_q <= a_d; st_q <= st_d; c_q <= c_d; acc_q <= acc_d;
    if (dload) begin
      dx_q[dj] <= pt_rd_q[95:64]; dy_q[dj] <= pt_rd_q[63:32];
      dz_q[dj] <= pt_rd_q[31:0];
    end
    if (blend_wr) begin
      unique case (c_q)
        2'd0:    dx_q[j_q[2:0]] <= blended[31:0];
        2'd1:    dy_q[j_q[2:0]] <= blended[31:0];
        default: dz_q[j_q[2:0]] <= blended[31:0];
      endcase
    end
    if (out_load) begin
      ox_q <= rx_d; oy_q <= ry_d; oz_q <= rz_d; osp_q <= rsp_d; ost_q <= rst_d;
    end
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = ov_q;
  assign out_x_o      = ox_q;
  assign out_y_o      = oy_q;
  assign out_z_o      = oz_q;
  assign span_found_o = osp_q;
  assign status_o     = ost_q;

endmodule

// ----- sv/bspe_checker.sv -----
// ----------------------------------------------------------------------------
// B-spline point evaluator checker
// Port-level properties of the evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module bspe_checker import bspe_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] status_o,
  input logic [5:0] span_found_o
);

  // A result waiting under stall keeps its status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
    else $error("stalled result changed");

  // An accepted transaction closes the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open while busy");

  // No new result appears while the input is open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_stall_o)
    else $error("result without transaction");

  // Failed or rejected requests report no span.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_BAD || status_o == ST_NO_SPAN) |-> span_found_o == 6'd0)
    else $error("span reported on failure");

endmodule

bind b_spline_point_evaluator bspe_checker u_bspe_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
  .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .status_o(status_o),
  .span_found_o(span_found_o)
);

// ----- sim/b_spline_point_evaluator_tb.sv -----
// ----------------------------------------------------------------------------
// B-spline point evaluator testbench
// Loads control points and knots, then evaluates curve points under a range
// of degree, point count and knot mode settings. Every transaction is predicted
// by a local de Boor model and checked field by field against the block.
// ----------------------------------------------------------------------------
module b_spline_point_evaluator_tb;
  import bspe_pkg::*;

  localparam int Limit = 10000000;
  localparam longint One = 65536;

  typedef struct {
    req_e        req;
    logic [5:0]  idx;
    logic [31:0] cx, cy, cz;
    logic [9:0]  kv;
    logic [16:0] prog;
  } item_t;

  typedef struct {
    logic [31:0] x, y, z;
    logic [5:0]  span;
    status_e     st;
  } point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [5:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] req_type_i = '0;
  logic [5:0] index_i = '0;
  logic signed [31:0] coord_x_i = '0, coord_y_i = '0, coord_z_i = '0;
  logic [9:0] knot_value_i = '0;
  logic [16:0] progress_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] out_x_o, out_y_o, out_z_o;
  logic [5:0] span_found_o;
  logic [1:0] status_o;

  b_spline_point_evaluator uut (.*);

  always #5 clk_i = ~clk_i;

  item_t  pending_q[$];
  point_t expected_q[$];
  int unsigned errors = 0, offered = 0, accepted = 0, cycles = 0;
  int unsigned send_gap = 0, stall_gap = 0;
  bit quiet = 0, hold = 0, hold_go = 0;

  // Local copy of the block's state.
  logic [31:0] pt_x[MaxPoints], pt_y[MaxPoints], pt_z[MaxPoints];
  logic [9:0]  kn[KnotDepth];
  int unsigned m_deg = 3, m_num = 4, m_mode = 1;

  function automatic void add_item(item_t it);
    pending_q.insert(pending_q.size(), it);
  endfunction

  function automatic longint knot_at(int unsigned i);
    if (m_mode != 0) begin
      if (m_deg == 1) return longint'(i);
      if (i < m_deg) return 0;
      if (i < m_num) return longint'(i - m_deg);
      return longint'(m_num - m_deg);
    end
    if (i >= KnotDepth) return 0;
    return longint'(kn[i]);
  endfunction

  function automatic point_t evaluate(item_t it);
    point_t res;
    longint d[0:MaxDegree][0:2];
    longint prog, lo, hi, x, ta, tb, den, a;
    int unsigned p, n, k, ci;
    bit found;
    res = '{x: '0, y: '0, z: '0, span: '0, st: ST_OK};
    found = 0;
    k = 0;
    case (it.req)
      REQ_POINT: begin
        if (it.idx >= MaxPoints) res.st = ST_BAD;
        else begin
          pt_x[it.idx] = it.cx;
          pt_y[it.idx] = it.cy;
          pt_z[it.idx] = it.cz;
        end
      end
      REQ_KNOT: kn[it.idx] = it.kv;
      REQ_EVAL: begin
        p = m_deg;
        n = m_num;
        if (p < 1 || p > MaxDegree || n < p + 1 || n > MaxPoints || n + p + 1 > KnotDepth) begin
          res.st = ST_BAD;
          return res;
        end
        prog = longint'(it.prog);
        if (prog > One) prog = One;
        lo = knot_at(p);
        hi = knot_at(n);
        x = lo * One + prog * (hi - lo);
        for (int unsigned j = p; j + 1 <= n && !found; j++) begin
          if (knot_at(j) * One <= x && x <= knot_at(j + 1) * One) begin
            k = j;
            found = 1;
          end
        end
        if (!found) begin
          res.st = ST_NO_SPAN;
          return res;
        end
        for (int unsigned j = 0; j <= p; j++) begin
          ci = j + k - p;
          d[j][0] = longint'($signed(pt_x[ci]));
          d[j][1] = longint'($signed(pt_y[ci]));
          d[j][2] = longint'($signed(pt_z[ci]));
        end
        for (int r = 1; r <= p; r++) begin
          for (int j = p; j >= r; j--) begin
            ta = knot_at(j + k - p);
            tb = knot_at(j + 1 + k - r);
            den = tb - ta;
            a = 0;
            if (den == 0) res.st = ST_ZERO;
            else begin
              a = (x - ta * One) / den;
              if (a < 0) a = 0;
              if (a > One) a = One;
            end
            for (int c = 0; c < 3; c++)
              d[j][c] = ((One - a) * d[j-1][c] + a * d[j][c]) / One;
          end
        end
        res.x = d[p][0][31:0];
        res.y = d[p][1][31:0];
        res.z = d[p][2][31:0];
        res.span = k[5:0];
      end
      default: res.st = ST_BAD;
    endcase
    return res;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Input side: prediction happens at the edge that accepts the transaction.
  always @(posedge clk_i) begin
    item_t it;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      it.req = req_e'(req_type_i);
      it.idx = index_i;
      it.cx = coord_x_i;
      it.cy = coord_y_i;
      it.cz = coord_z_i;
      it.kv = knot_value_i;
      it.prog = progress_i;
      expected_q.insert(expected_q.size(), evaluate(it));
      accepted++;
    end
  end

  always @(posedge clk_i) begin
    point_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        report("unexpected result", 32'(status_o), 32'd0);
      end else begin
        e = expected_q.pop_front();
        if (out_x_o !== e.x) report("out_x", out_x_o, e.x);
        if (out_y_o !== e.y) report("out_y", out_y_o, e.y);
        if (out_z_o !== e.z) report("out_z", out_z_o, e.z);
        if (span_found_o !== e.span) report("span_found", 32'(span_found_o), 32'(e.span));
        if (status_o !== e.st) report("status", 32'(status_o), 32'(e.st));
      end
    end
  end

  always @(negedge clk_i) begin
    item_t it;
    if (rst_ni && (!in_valid_i || accepted == offered)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() > 0) begin
        it = pending_q.pop_front();
        req_type_i <= it.req;
        index_i <= it.idx;
        coord_x_i <= it.cx;
        coord_y_i <= it.cy;
        coord_z_i <= it.cz;
        knot_value_i <= it.kv;
        progress_i <= it.prog;
        in_valid_i <= 1'b1;
        offered++;
        if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 9);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    logic s;
    s = hold;
    if (stall_gap > 0) begin
      stall_gap--;
      s = 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_gap = $urandom_range(0, 8);
      s = 1'b1;
    end
    out_stall_i <= s;
  end

  // Long receiver hold-off so that the block fills and stalls its input.
  initial begin
    wait (hold_go);
    @(posedge clk_i);
    hold = 1'b1;
    repeat (600) @(posedge clk_i);
    hold = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > Limit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic item_t blank(req_e r);
    item_t it;
    it = '{req: r, idx: '0, cx: '0, cy: '0, cz: '0, kv: '0, prog: '0};
    return it;
  endfunction

  function automatic item_t point_load(logic [5:0] idx);
    item_t it;
    it = blank(REQ_POINT);
    it.idx = idx;
    it.cx = $urandom;
    it.cy = $urandom;
    it.cz = $urandom;
    case ($urandom_range(0, 9))
      0: it.cx = 32'h8000_0000;
      1: it.cy = 32'h7fff_ffff;
      2: it.cz = 32'h0;
      default: ;
    endcase
    return it;
  endfunction

  function automatic item_t knot_load(logic [5:0] idx, logic [9:0] v);
    item_t it;
    it = blank(REQ_KNOT);
    it.idx = idx;
    it.kv = v;
    return it;
  endfunction

  function automatic item_t eval_req(logic [16:0] prog);
    item_t it;
    it = blank(REQ_EVAL);
    it.idx = 6'($urandom);
    it.cx = $urandom;
    it.kv = 10'($urandom);
    it.prog = prog;
    return it;
  endfunction

  function automatic logic [16:0] pick_progress();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  // Nondecreasing knots; repeats make zero-length spans.
  task automatic sorted_knots();
    int unsigned v;
    v = $urandom_range(0, 3);
    for (int i = 0; i < KnotDepth; i++) begin
      add_item(knot_load(6'(i), 10'(v)));
      v += ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 3);
    end
  endtask

  function automatic item_t random_item(int unsigned mode);
    int unsigned sel;
    item_t it;
    sel = $urandom_range(0, 99);
    if (sel < 30) begin
      return point_load(6'(($urandom_range(0, 9) == 0) ? $urandom_range(32, 63)
                                                        : $urandom_range(0, 31)));
    end else if (sel < 42) begin
      // In loaded-knot mode, mostly touch slots beyond the active vector.
      if (mode == 0 && $urandom_range(0, 9) != 0)
        return knot_load(6'($urandom_range(40, 63)), 10'($urandom));
      return knot_load(6'($urandom), 10'($urandom));
    end else if (sel < 46) begin
      it = blank(REQ_BAD);
      it.idx = 6'($urandom);
      it.prog = 17'($urandom);
      return it;
    end
    return eval_req(pick_progress());
  endfunction

  task automatic wait_idle();
    while (pending_q.size() != 0 || accepted != offered || expected_q.size() != 0)
      @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_cfg(cfg_e idx, int unsigned val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[5:0];
    case (idx)
      CFG_DEGREE: m_deg = val & 7;
      CFG_NUM:    m_num = val & 63;
      default:    m_mode = val & 1;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int unsigned deg_t[10]  = '{1, 2, 7, 1, 4, 0, 5, 7, 3, 2};
    int unsigned num_t[10]  = '{2, 10, 32, 32, 9, 5, 3, 8, 63, 6};
    int unsigned mode_t[10] = '{1, 0, 1, 0, 0, 1, 1, 0, 1, 0};
    int unsigned cnt_t[10]  = '{60, 80, 20, 80, 80, 20, 20, 20, 14, 70};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Fill both stores before any evaluation reads them.
    for (int i = 0; i < MaxPoints; i++) add_item(point_load(6'(i)));
    sorted_knots();
    add_item(eval_req(17'd0));
    add_item(eval_req(17'd65536));
    add_item(eval_req(17'd65537));
    add_item(eval_req(17'h1ffff));
    add_item(eval_req(17'd32768));
    add_item(eval_req(17'd1));
    add_item(point_load(6'd63));
    add_item(point_load(6'd32));
    add_item(blank(REQ_BAD));
    add_item(knot_load(6'd63, 10'h3ff));
    add_item(knot_load(6'd62, 10'h0));
    add_item(eval_req(17'd21845));
    wait_idle();

    for (int ph = 0; ph < 10; ph++) begin
      write_cfg(CFG_DEGREE, deg_t[ph]);
      write_cfg(CFG_NUM, num_t[ph]);
      write_cfg(CFG_MODE, mode_t[ph]);
      if (ph == 9) quiet = 1;
      if (mode_t[ph] == 0) begin
        sorted_knots();
        // Scramble part of the active vector: spans may vanish or run backward.
        if (ph == 7)
          for (int i = 2; i < 10; i++) add_item(knot_load(6'(i), 10'($urandom_range(0, 15))));
      end
      if (ph == 1) hold_go = 1;
      for (int i = 0; i < cnt_t[ph]; i++) add_item(random_item(mode_t[ph]));
      wait_idle();
    end

    repeat (50) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
